// ===== hw/rtl/pada_pkg.sv =====
// Shared types, constants and arithmetic helpers of the polygon area deviation averager.
package pada_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_CELLS    = 1024;
  localparam int unsigned MAX_FRAMES   = 65536;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned VCNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CCNT_W  = $clog2(MAX_CELLS + 1);
  localparam int unsigned FCNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PROD_W  = 2 * COORD_W;
  localparam int unsigned TERM_W  = PROD_W + 1;
  localparam int unsigned NN_W    = 2 * VCNT_W;
  localparam int unsigned TGT_W   = COEF_W + NN_W;
  localparam int unsigned STEP_W  = $clog2(SUM_W);

  // Frame queue between the front and back parts
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [COEF_W-1:0] COEF_RST = COEF_W'(300393);
  localparam logic [VCNT_W-1:0] VCNT_MAX = VCNT_W'(MAX_VERTICES);
  localparam logic [CCNT_W-1:0] CCNT_MAX = CCNT_W'(MAX_CELLS);
  localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(MAX_FRAMES);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);
  localparam logic [QCNT_W-1:0] QCRED_INIT = QCNT_W'(QDEPTH);

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [FCNT_W-1:0]       div_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    sum_t val;
    logic ovf;
  } sat_t;

  // One closed frame: deviation sum, cell count, overflow seen, last of run
  typedef struct packed {
    sum_t              fsum;
    logic [CCNT_W-1:0] ccnt;
    logic              ovf;
    logic              eor;
  } frame_rec_t;

  typedef struct packed {
    logic start;
    sum_t dividend;
    div_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    sum_t quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FDIV,
    BK_FACC,
    BK_RSTART,
    BK_RDIV,
    BK_OUT
  } back_state_e;

  // Signed add that clamps at the 64-bit limits and flags the clamp
  function automatic sat_t sat_add(sum_t a, sum_t b);
    sat_t r;
    sum_t s;
    s     = a + b;
    r.val = s;
    r.ovf = 1'b0;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
      r.ovf = 1'b1;
      r.val = b[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/polygon_area_deviation_averager.sv =====
// Top level of the polygon area deviation averager: front, frame queue and back.
//
// Usage:
//  - Input channel (push/full): one polygon vertex per item, vx_i/vy_i in signed
//    Q12.12 with end_of_cell_i, end_of_frame_i and end_of_run_i. A higher end flag
//    implies the lower ones. Accepted when push is high and full is low.
//  - Result channel (empty/pop): one item per run, given on the last vertex of
//    the run: mean_area_diff_o (signed Q40.24), frames_seen_o and saturated_o.
//    Valid while empty is low, taken when pop is high.
//  - target_coef_we_i writes target_coef_i (Q0.24); write only while idle.
// Throughput: one vertex per cycle while full is low. The front is a pipeline
// with no internal stall. Each closed frame costs the back part a division by
// the shared one-bit-per-cycle divider; a four-entry frame queue absorbs bursts
// of short frames, and full rises once four frame ends are in flight.
// A run's result passes through the front stages, the queue, frame division,
// run division and result load.
// Reset: clears all cell, frame and run state and restores target_coef to its
// default. A stalled result holds the back part in its output state; the front
// keeps accepting until the queue credit runs out.
module polygon_area_deviation_averager (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [pada_pkg::COORD_W-1:0] vx_i,
  input  logic signed [pada_pkg::COORD_W-1:0] vy_i,
  input  logic                              end_of_cell_i,
  input  logic                              end_of_frame_i,
  input  logic                              end_of_run_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [pada_pkg::SUM_W-1:0] mean_area_diff_o,
  output logic [pada_pkg::FCNT_W-1:0]       frames_seen_o,
  output logic                              saturated_o,
  input  logic                              target_coef_we_i,
  input  logic [pada_pkg::COEF_W-1:0]       target_coef_i
);

  logic [pada_pkg::COEF_W-1:0] coef_q;
  logic                        rec_push, q_pop, q_empty;
  pada_pkg::frame_rec_t        rec, q_head;

  // Target coefficient register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= pada_pkg::COEF_RST;
    end else if (target_coef_we_i) begin
      coef_q <= target_coef_i;
    end
  end

  // Front: per-vertex shoelace sums, cell deviations, frame sums
  pada_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .vx_i           (vx_i),
    .vy_i           (vy_i),
    .end_of_cell_i  (end_of_cell_i),
    .end_of_frame_i (end_of_frame_i),
    .end_of_run_i   (end_of_run_i),
    .coef_i         (coef_q),
    .q_pop_i        (q_pop),
    .rec_push_o     (rec_push),
    .rec_o          (rec)
  );

  // Queue of closed frames; space is reserved by the front's credit count
  pada_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rec_push),
    .push_data_i (rec),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  // Back: frame and run averaging through the shared divider
  pada_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .empty            (empty),
    .pop              (pop),
    .mean_area_diff_o (mean_area_diff_o),
    .frames_seen_o    (frames_seen_o),
    .saturated_o      (saturated_o)
  );

endmodule

// ===== hw/rtl/pada_fifo.sv =====
// Small queue of closed frame records between the front and back parts.
module pada_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pada_pkg::frame_rec_t  push_data_i,
  input  logic                  pop_i,
  output pada_pkg::frame_rec_t  head_o,
  output logic                  empty_o
);

  pada_pkg::frame_rec_t              mem_q [pada_pkg::QDEPTH];
  logic [pada_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [pada_pkg::QCNT_W-1:0]       cnt_q;
  logic                              do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pada_front.sv =====
// Front part: vertex pipeline building cell areas, deviations and frame records.
module pada_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic signed [pada_pkg::COORD_W-1:0] vx_i,
  input  logic signed [pada_pkg::COORD_W-1:0] vy_i,
  input  logic                           end_of_cell_i,
  input  logic                           end_of_frame_i,
  input  logic                           end_of_run_i,
  input  logic [pada_pkg::COEF_W-1:0]    coef_i,
  input  logic                           q_pop_i,
  output logic                           rec_push_o,
  output pada_pkg::frame_rec_t           rec_o
);

  logic acc, eor, eof, eoc, first, vovf;
  logic [pada_pkg::VCNT_W-1:0] vinc;
  logic signed [pada_pkg::COORD_W-1:0] fx, fy;

  // Cell tracking at the input
  logic [pada_pkg::VCNT_W-1:0]         vcnt_q;
  logic signed [pada_pkg::COORD_W-1:0] fst_x_q, fst_y_q, prv_x_q, prv_y_q;
  logic [pada_pkg::QCNT_W-1:0]         cred_q;

  // Stage 1: products
  logic                              v1_q;
  logic signed [pada_pkg::PROD_W-1:0] s1_pa_q, s1_pb_q, s1_ca_q, s1_cb_q;
  logic                              s1_first_q, s1_eoc_q, s1_eof_q, s1_eor_q, s1_ovf_q;
  logic [pada_pkg::VCNT_W-1:0]       s1_n_q;

  // Stage 2: cross and closing terms, n squared
  logic                              v2_q;
  logic signed [pada_pkg::TERM_W-1:0] s2_d_q, s2_e_q;
  logic [pada_pkg::NN_W-1:0]         s2_nn_q;
  logic                              s2_eoc_q, s2_eof_q, s2_eor_q, s2_ovf_q;

  // Stage 3: cross sum
  logic                              v3_q;
  pada_pkg::sum_t                    cs_q, s3_cs_q;
  logic signed [pada_pkg::TERM_W-1:0] s3_e_q;
  logic [pada_pkg::NN_W-1:0]         s3_nn_q;
  logic                              s3_eoc_q, s3_eof_q, s3_eor_q, s3_ovf_q;
  pada_pkg::sat_t                    cs_add;

  // Stage 4: closed sum and target
  logic                              v4_q;
  pada_pkg::sum_t                    s4_cl_q;
  logic [pada_pkg::TGT_W-1:0]        s4_tgt_q;
  logic                              s4_eoc_q, s4_eof_q, s4_eor_q, s4_ovf_q;
  pada_pkg::sat_t                    cl_add;

  // Stage 5: area
  logic                              v5_q;
  pada_pkg::sum_t                    s5_area_q, half;
  logic [pada_pkg::TGT_W-1:0]        s5_tgt_q;
  logic                              s5_eoc_q, s5_eof_q, s5_eor_q, s5_ovf_q;

  // Stage 6: deviation
  logic                              v6_q;
  pada_pkg::sum_t                    s6_dev_q;
  logic                              s6_eoc_q, s6_eof_q, s6_eor_q, s6_ovf_q;

  // Frame accumulation
  pada_pkg::sum_t                    fsum_q;
  logic [pada_pkg::CCNT_W-1:0]       ccnt_q, cinc;
  logic                              fovf_q, covf, ovf_all;
  pada_pkg::sat_t                    fs_add;

  assign full  = (cred_q == '0);
  assign acc   = push && !full;
  assign eor   = end_of_run_i;
  assign eof   = eor || end_of_frame_i;
  assign eoc   = eof || end_of_cell_i;
  assign first = (vcnt_q == '0);
  assign vovf  = (vcnt_q >= pada_pkg::VCNT_MAX);
  assign vinc  = vovf ? pada_pkg::VCNT_MAX : vcnt_q + 1'b1;
  assign fx    = first ? vx_i : fst_x_q;
  assign fy    = first ? vy_i : fst_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
      cred_q <= pada_pkg::QCRED_INIT;
    end else begin
      if (acc) begin
        vcnt_q <= eoc ? '0 : vinc;
      end
      case ({acc && eof, q_pop_i})
        2'b10:   cred_q <= cred_q - 1'b1;
        2'b01:   cred_q <= cred_q + 1'b1;
        default: cred_q <= cred_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (first) begin
        fst_x_q <= vx_i;
        fst_y_q <= vy_i;
      end
      prv_x_q    <= vx_i;
      prv_y_q    <= vy_i;
      s1_pa_q    <= prv_x_q * vy_i;
      s1_pb_q    <= vx_i * prv_y_q;
      s1_ca_q    <= vx_i * fy;
      s1_cb_q    <= fx * vy_i;
      s1_first_q <= first;
      s1_eoc_q   <= eoc;
      s1_eof_q   <= eof;
      s1_eor_q   <= eor;
      s1_ovf_q   <= vovf;
      s1_n_q     <= vinc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_first_q) begin
      s2_d_q <= '0;
    end else begin
      s2_d_q <= s1_pa_q - s1_pb_q;
    end
    s2_e_q   <= s1_ca_q - s1_cb_q;
    s2_nn_q  <= s1_n_q * s1_n_q;
    s2_eoc_q <= s1_eoc_q;
    s2_eof_q <= s1_eof_q;
    s2_eor_q <= s1_eor_q;
    s2_ovf_q <= s1_ovf_q;
  end

  assign cs_add = pada_pkg::sat_add(cs_q, pada_pkg::sum_t'(s2_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= '0;
    end else if (v2_q) begin
      cs_q <= s2_eoc_q ? '0 : cs_add.val;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_cs_q  <= cs_add.val;
    s3_e_q   <= s2_e_q;
    s3_nn_q  <= s2_nn_q;
    s3_eoc_q <= s2_eoc_q;
    s3_eof_q <= s2_eof_q;
    s3_eor_q <= s2_eor_q;
    s3_ovf_q <= s2_ovf_q || cs_add.ovf;
  end

  assign cl_add = pada_pkg::sat_add(s3_cs_q, pada_pkg::sum_t'(s3_e_q));

  always_ff @(posedge clk_i) begin
    s4_cl_q  <= cl_add.val;
    s4_tgt_q <= coef_i * s3_nn_q;
    s4_eoc_q <= s3_eoc_q;
    s4_eof_q <= s3_eof_q;
    s4_eor_q <= s3_eor_q;
    // The closing term is only added on the last vertex of a cell
    s4_ovf_q <= s3_ovf_q || (cl_add.ovf && s3_eoc_q);
  end

  // Halve, truncating toward zero
  assign half = s4_cl_q >>> 1;

  always_ff @(posedge clk_i) begin
    s5_area_q <= half + pada_pkg::sum_t'(s4_cl_q[pada_pkg::SUM_W-1] && s4_cl_q[0]);
    s5_tgt_q  <= s4_tgt_q;
    s5_eoc_q  <= s4_eoc_q;
    s5_eof_q  <= s4_eof_q;
    s5_eor_q  <= s4_eor_q;
    s5_ovf_q  <= s4_ovf_q;
  end

  always_ff @(posedge clk_i) begin
    s6_dev_q <= s5_area_q - pada_pkg::sum_t'(s5_tgt_q);
    s6_eoc_q <= s5_eoc_q;
    s6_eof_q <= s5_eof_q;
    s6_eor_q <= s5_eor_q;
    s6_ovf_q <= s5_ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign fs_add  = pada_pkg::sat_add(fsum_q, s6_dev_q);
  assign covf    = (ccnt_q >= pada_pkg::CCNT_MAX);
  assign cinc    = covf ? pada_pkg::CCNT_MAX : ccnt_q + 1'b1;
  assign ovf_all = fovf_q || s6_ovf_q || (s6_eoc_q && (fs_add.ovf || covf));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsum_q <= '0;
      ccnt_q <= '0;
      fovf_q <= 1'b0;
    end else if (v6_q) begin
      if (s6_eof_q) begin
        fsum_q <= '0;
        ccnt_q <= '0;
        fovf_q <= 1'b0;
      end else begin
        if (s6_eoc_q) begin
          fsum_q <= fs_add.val;
          ccnt_q <= cinc;
        end
        fovf_q <= ovf_all;
      end
    end
  end

  assign rec_push_o = v6_q && s6_eof_q;
  assign rec_o.fsum = fs_add.val;
  assign rec_o.ccnt = cinc;
  assign rec_o.ovf  = ovf_all;
  assign rec_o.eor  = s6_eor_q;

endmodule

// ===== hw/rtl/pada_div.sv =====
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
module pada_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pada_pkg::div_req_t req_i,
  output pada_pkg::div_rsp_t rsp_o
);

  logic                              busy_q, done_q, neg_q;
  logic [pada_pkg::STEP_W-1:0]       step_q;
  logic [pada_pkg::SUM_W-1:0]        dq_q, mag;
  pada_pkg::div_t                    dvs_q, rem_q;
  logic [pada_pkg::FCNT_W:0]         r2, diff;
  logic                              ge;

  assign mag  = req_i.dividend[pada_pkg::SUM_W-1] ? -req_i.dividend : req_i.dividend;
  assign r2   = {rem_q, dq_q[pada_pkg::SUM_W-1]};
  assign diff = r2 - {1'b0, dvs_q};
  assign ge   = (r2 >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == pada_pkg::STEP_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= mag;
      neg_q <= req_i.dividend[pada_pkg::SUM_W-1];
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[pada_pkg::FCNT_W-1:0] : r2[pada_pkg::FCNT_W-1:0];
      dq_q  <= {dq_q[pada_pkg::SUM_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -pada_pkg::sum_t'(dq_q) : pada_pkg::sum_t'(dq_q);

endmodule

// ===== hw/rtl/pada_back.sv =====
// Back part: frame averaging, run averaging and the result register.
module pada_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  pada_pkg::frame_rec_t           q_head_i,
  output logic                           q_pop_o,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [pada_pkg::SUM_W-1:0] mean_area_diff_o,
  output logic [pada_pkg::FCNT_W-1:0]    frames_seen_o,
  output logic                           saturated_o
);

  pada_pkg::back_state_e       state_q, state_d;
  pada_pkg::div_req_t          dreq;
  pada_pkg::div_rsp_t          drsp;
  pada_pkg::sum_t              run_q, quo_q;
  logic [pada_pkg::FCNT_W-1:0] fcnt_q;
  logic                        rovf_q, eor_q, res_valid_q, res_load, fovf;
  pada_pkg::sat_t              run_add;

  pada_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign run_add = pada_pkg::sat_add(run_q, quo_q);
  assign fovf    = (fcnt_q >= pada_pkg::FCNT_MAX);

  always_comb begin
    state_d       = state_q;
    q_pop_o       = 1'b0;
    res_load      = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = q_head_i.fsum;
    dreq.divisor  = pada_pkg::div_t'(q_head_i.ccnt);
    case (state_q)
      pada_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o    = 1'b1;
          dreq.start = 1'b1;
          state_d    = pada_pkg::BK_FDIV;
        end
      end
      pada_pkg::BK_FDIV: begin
        if (drsp.done) begin
          state_d = pada_pkg::BK_FACC;
        end
      end
      pada_pkg::BK_FACC: begin
        state_d = eor_q ? pada_pkg::BK_RSTART : pada_pkg::BK_IDLE;
      end
      pada_pkg::BK_RSTART: begin
        dreq.start    = 1'b1;
        dreq.dividend = run_q;
        dreq.divisor  = fcnt_q;
        state_d       = pada_pkg::BK_RDIV;
      end
      pada_pkg::BK_RDIV: begin
        if (drsp.done) begin
          state_d = pada_pkg::BK_OUT;
        end
      end
      pada_pkg::BK_OUT: begin
        // Hold until the result register is free
        if (!res_valid_q || pop) begin
          res_load = 1'b1;
          state_d  = pada_pkg::BK_IDLE;
        end
      end
      default: state_d = pada_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pada_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      fcnt_q <= '0;
      rovf_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        rovf_q <= rovf_q || q_head_i.ovf;
      end else if (state_q == pada_pkg::BK_FACC) begin
        run_q  <= run_add.val;
        fcnt_q <= fovf ? pada_pkg::FCNT_MAX : fcnt_q + 1'b1;
        rovf_q <= rovf_q || run_add.ovf || fovf;
      end else if (res_load) begin
        run_q  <= '0;
        fcnt_q <= '0;
        rovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      eor_q <= q_head_i.eor;
    end
    if (drsp.done) begin
      quo_q <= drsp.quo;
    end
    if (res_load) begin
      mean_area_diff_o <= quo_q;
      frames_seen_o    <= fcnt_q;
      saturated_o      <= rovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (pop) begin
      res_valid_q <= 1'b0;
    end
  end

  assign empty = !res_valid_q;

endmodule
